/* rtl/date_to_day_number_weekday_assert.svh */
// Assertion macros for the date to day number block.
`ifndef DATE_TO_DAY_NUMBER_WEEKDAY_ASSERT_SVH
`define DATE_TO_DAY_NUMBER_WEEKDAY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define D2D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define D2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/d2d_pkg.sv */
package d2d_pkg;

    localparam logic [13:0] BASE_YEAR   = 14'd1900;
    localparam logic [11:0] BASE_LEAPS  = 12'd460;   // leap years in 1..1899
    localparam logic [3:0]  MONTH_JAN   = 4'd1;
    localparam logic [3:0]  MONTH_FEB   = 4'd2;
    localparam logic [3:0]  MONTH_DEC   = 4'd12;
    localparam logic [11:0] RECIP_25    = 12'd2622;  // ceil(2^16 / 25)
    localparam int          RECIP_SHIFT = 16;
    localparam int          COUNT_W     = 23;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        rng_ok;     // year and month in range
        logic [7:0]  q100_prev;  // (year-1) / 100
        logic [5:0]  q400_prev;  // (year-1) / 400
        logic [7:0]  q100;       // year / 100
        logic [5:0]  q400;       // year / 400
    } t_s1;

    typedef struct packed {
        logic        ok;
        logic [22:0] year_days;  // (year-1900) * 365
        logic [11:0] leaps;      // leap days from 1900 up to year-1
        logic [8:0]  doy;        // day of year
    } t_s2;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of month m in a common year.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/date_to_day_number_weekday.sv */
// Gregorian date to day number and weekday.
// Input stream: one date per transfer on s_axis; tdata carries year (14 bits),
// month (4 bits) and day (5 bits). Output stream: one result per date on
// m_axis; tuser is the valid-date flag, tdata carries the day count (days
// since 1899-12-31, so 1900-01-01 is 1) and the weekday (0 Sunday..6 Saturday).
// An invalid date (year outside 1900..MAX_YEAR, bad month, day 0 or past the
// end of the month, February 29 of a common year) yields flag 0, count 0 and
// weekday 0.
// Four register stages: year quotients, calendar checks and partial sums,
// final add, weekday fold into the output register. Throughput is one date
// per cycle while the receiver takes results; each stage holds a valid bit
// and moves on when the stage after it is empty or moving, so bubbles
// close up.
// If the receiver stalls, the pipeline fills and s_axis_tready falls only
// once every stage holds an item; no transfer is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; the output is
// empty and the input ready right after.
module date_to_day_number_weekday #(
    parameter int MAX_YEAR = 9999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [13:0] year_in, [17:14] month_in,
                                        // [22:18] day_in, [23] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [21:0] day_count, [24:22] weekday,
                                        // [31:25] zero
    output logic        m_axis_tuser    // [0] date_valid
);

`include "date_to_day_number_weekday_assert.svh"

    // per-stage valid bits
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    d2d_pkg::t_s1 s1;
    d2d_pkg::t_s2 s2;

    logic                        r_ok3;
    logic [d2d_pkg::COUNT_W-1:0] r_count3;
    logic [d2d_pkg::COUNT_W-1:0] n_count3;

    logic        out_ok;
    logic [21:0] out_count;
    logic [2:0]  out_weekday;

    // a stage loads when it is empty or its content moves on
    assign en4 = !r_v4 || m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    d2d_year_div #(
        .MAX_YEAR (MAX_YEAR)
    ) u_year_div (
        .i_clk   (i_clk),
        .i_en    (en1),
        .i_year  (s_axis_tdata[13:0]),
        .i_month (s_axis_tdata[17:14]),
        .i_day   (s_axis_tdata[22:18]),
        .o_s1    (s1)
    );

    d2d_date_chk u_date_chk (
        .i_clk (i_clk),
        .i_en  (en2),
        .i_s1  (s1),
        .o_s2  (s2)
    );

    // stage 3: total day count, forced to zero for a bad date
    assign n_count3 = s2.ok ? (s2.year_days + 23'(s2.leaps) + 23'(s2.doy))
                            : '0;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_ok3    <= s2.ok;
            r_count3 <= n_count3;
        end
    end

    d2d_mod7 u_mod7 (
        .i_clk       (i_clk),
        .i_en        (en4),
        .i_ok        (r_ok3),
        .i_count     (r_count3),
        .o_ok        (out_ok),
        .o_day_count (out_count),
        .o_weekday   (out_weekday)
    );

    assign m_axis_tvalid = r_v4;
    assign m_axis_tuser  = out_ok;
    assign m_axis_tdata  = {7'd0, out_weekday, out_count};

    // bad date carries a zero payload
    `D2D_ASSERT_NOW(a_bad_date_zero, r_v4 && !out_ok,
        (out_count == 22'd0) && (out_weekday == 3'd0), "bad date with nonzero result")
    // weekday of a good date stays below 7 (the count may wrap at 22 bits)
    `D2D_ASSERT_NOW(a_good_date_range, r_v4 && out_ok,
        (out_weekday != 3'd7), "good date result out of range")
    // full pipeline with a stalled output must refuse input
    `D2D_ASSERT_NOW(a_full_stall, r_v1 && r_v2 && r_v3 && r_v4 && !m_axis_tready,
        !s_axis_tready, "input taken while pipeline full")
    // an item waiting in stage 3 under a stalled full output stays put
    `D2D_ASSERT_NEXT(a_stage3_hold, r_v3 && r_v4 && !m_axis_tready,
        r_v3 && $stable(r_count3), "stage 3 item lost under stall")

endmodule

/* rtl/d2d_year_div.sv */
// Stage 1: range checks and year quotients by 100 and 400.
// x / 25 = (x * 2622) >> 16, exact for x below 4681.
module d2d_year_div #(
    parameter int MAX_YEAR = 9999
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [13:0]   i_year,
    input  logic [3:0]    i_month,
    input  logic [4:0]    i_day,
    output d2d_pkg::t_s1  o_s1
);

    logic [13:0]  ym1;
    logic [23:0]  p100_prev;
    logic [21:0]  p400_prev;
    logic [23:0]  p100;
    logic [21:0]  p400;
    d2d_pkg::t_s1 n_s1;
    d2d_pkg::t_s1 r_s1;

    always_comb begin
        ym1       = i_year - 14'd1;
        p100_prev = 24'(ym1[13:2]) * 24'(d2d_pkg::RECIP_25);
        p400_prev = 22'(ym1[13:4]) * 22'(d2d_pkg::RECIP_25);
        p100      = 24'(i_year[13:2]) * 24'(d2d_pkg::RECIP_25);
        p400      = 22'(i_year[13:4]) * 22'(d2d_pkg::RECIP_25);

        n_s1.year      = i_year;
        n_s1.month     = i_month;
        n_s1.day       = i_day;
        n_s1.rng_ok    = (i_year >= d2d_pkg::BASE_YEAR) && (i_year <= 14'(MAX_YEAR))
                         && (i_month >= d2d_pkg::MONTH_JAN)
                         && (i_month <= d2d_pkg::MONTH_DEC);
        n_s1.q100_prev = p100_prev[d2d_pkg::RECIP_SHIFT +: 8];
        n_s1.q400_prev = p400_prev[d2d_pkg::RECIP_SHIFT +: 6];
        n_s1.q100      = p100[d2d_pkg::RECIP_SHIFT +: 8];
        n_s1.q400      = p400[d2d_pkg::RECIP_SHIFT +: 6];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

/* rtl/d2d_date_chk.sv */
// Stage 2: leap test, day check, year days, leap days and day of year.
module d2d_date_chk (
    input  logic          i_clk,
    input  logic          i_en,
    input  d2d_pkg::t_s1  i_s1,
    output d2d_pkg::t_s2  o_s2
);

    logic         leap;
    logic [13:0]  ym1;
    logic [13:0]  yoff;
    logic [4:0]   mlen;
    logic         day_ok;
    d2d_pkg::t_s2 n_s2;
    d2d_pkg::t_s2 r_s2;

    always_comb begin
        ym1  = i_s1.year - 14'd1;
        yoff = i_s1.year - d2d_pkg::BASE_YEAR;
        // leap: divisible by 4, and not by 100 unless by 400
        leap = (i_s1.year[1:0] == 2'b00)
               && ((i_s1.year[13:2] != 12'(12'(i_s1.q100) * 12'd25))
                   || ((i_s1.year[3:0] == 4'd0)
                       && (i_s1.year[13:4] == 10'(10'(i_s1.q400) * 10'd25))));
        mlen   = d2d_pkg::month_len(i_s1.month)
                 + 5'(leap && (i_s1.month == d2d_pkg::MONTH_FEB));
        day_ok = (i_s1.day != 5'd0) && (i_s1.day <= mlen);

        n_s2.ok        = i_s1.rng_ok && day_ok;
        n_s2.year_days = 23'(yoff) * 23'd365;
        n_s2.leaps     = 12'(ym1[13:2]) - 12'(i_s1.q100_prev) + 12'(i_s1.q400_prev)
                         - d2d_pkg::BASE_LEAPS;
        n_s2.doy       = d2d_pkg::days_before(i_s1.month)
                         + 9'(leap && (i_s1.month > d2d_pkg::MONTH_FEB))
                         + 9'(i_s1.day);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

/* rtl/d2d_mod7.sv */
// Output stage: weekday by folding octal digits (8 = 1 mod 7).
module d2d_mod7 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic        i_ok,
    input  logic [22:0] i_count,
    output logic        o_ok,
    output logic [21:0] o_day_count,
    output logic [2:0]  o_weekday
);

    logic [23:0] cnt_ext;
    logic [5:0]  dsum;
    logic [3:0]  fold;
    logic [2:0]  red;
    logic [2:0]  n_weekday;
    logic        r_ok;
    logic [21:0] r_day_count;
    logic [2:0]  r_weekday;

    always_comb begin
        cnt_ext = {1'b0, i_count};
        dsum    = 6'd0;
        for (int k = 0; k < 8; k++) begin
            dsum = dsum + 6'(cnt_ext[3*k +: 3]);
        end
        fold      = 4'(dsum[5:3]) + 4'(dsum[2:0]);
        red       = (fold >= 4'd7) ? 3'(fold - 4'd7) : fold[2:0];
        n_weekday = (red == 3'd7) ? 3'd0 : red;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok        <= i_ok;
            r_day_count <= i_count[21:0];
            r_weekday   <= n_weekday;
        end
    end

    assign o_ok        = r_ok;
    assign o_day_count = r_day_count;
    assign o_weekday   = r_weekday;

endmodule

/* verif/date_to_day_number_weekday_tb.sv */
`timescale 1ns / 1ps

// Date to day number / weekday stream block.
// A short table of dates (bounds, leap-year rules, bad fields) runs first,
// then random dates: mostly well-formed ones with random content, some near
// the bounds and the month ends, some raw noise. Every transfer accepted on
// s_axis queues its expected result; every transfer on m_axis is compared
// field by field with the oldest one in the queue.
module date_to_day_number_weekday_tb;

    localparam int MAX_YEAR     = 9999;
    localparam int HALF_PERIOD  = 4;
    localparam int RANDOM_DATES = 500;
    localparam int HOLD_CYCLES  = 60;       // long receiver hold-off
    localparam int HOLD_AT      = 150;      // random date index that starts it
    localparam int DRAIN_AT     = 300;      // sender waits for an empty queue here
    localparam int DRAIN_CYCLES = 12;       // pipeline is four stages deep
    localparam int LIMIT_CYCLES = 200000;

    // One computed result: valid flag, 22-bit day count, weekday.
    typedef struct packed {
        logic        ok;
        logic [21:0] count;
        logic [2:0]  wday;
    } day_result_t;

    // Directed row. When known is set, the result in the row is taken as is,
    // otherwise the predictor supplies it.
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        known;
        logic        ok;
        logic [21:0] count;
        logic [2:0]  wday;
    } date_row_t;

    localparam int NUM_ROWS = 24;
    localparam date_row_t DATE_ROWS [NUM_ROWS] = '{
        '{14'd1900,  4'd1,  5'd1,  1'b1, 1'b1, 22'd1, 3'd1},  // first day, Monday
        '{14'd1900,  4'd1,  5'd2,  1'b1, 1'b1, 22'd2, 3'd2},
        '{14'd1899,  4'd12, 5'd31, 1'b1, 1'b0, 22'd0, 3'd0},  // year too low
        '{14'd0,     4'd0,  5'd0,  1'b1, 1'b0, 22'd0, 3'd0},  // all zero
        '{14'd16383, 4'd15, 5'd31, 1'b1, 1'b0, 22'd0, 3'd0},  // all ones
        '{14'd10000, 4'd1,  5'd1,  1'b1, 1'b0, 22'd0, 3'd0},  // year too high
        '{14'd9999,  4'd12, 5'd31, 1'b0, 1'b0, 22'd0, 3'd0},  // last valid day
        '{14'd2000,  4'd2,  5'd29, 1'b0, 1'b0, 22'd0, 3'd0},  // leap, div by 400
        '{14'd1900,  4'd2,  5'd29, 1'b1, 1'b0, 22'd0, 3'd0},  // century, common
        '{14'd2100,  4'd2,  5'd29, 1'b1, 1'b0, 22'd0, 3'd0},
        '{14'd2004,  4'd2,  5'd29, 1'b0, 1'b0, 22'd0, 3'd0},
        '{14'd1904,  4'd2,  5'd29, 1'b0, 1'b0, 22'd0, 3'd0},
        '{14'd2001,  4'd2,  5'd29, 1'b1, 1'b0, 22'd0, 3'd0},  // Feb 29, common year
        '{14'd2023,  4'd2,  5'd28, 1'b0, 1'b0, 22'd0, 3'd0},
        '{14'd2024,  4'd0,  5'd10, 1'b1, 1'b0, 22'd0, 3'd0},  // month 0
        '{14'd2024,  4'd13, 5'd10, 1'b1, 1'b0, 22'd0, 3'd0},  // month past December
        '{14'd2024,  4'd15, 5'd1,  1'b1, 1'b0, 22'd0, 3'd0},
        '{14'd2024,  4'd5,  5'd0,  1'b1, 1'b0, 22'd0, 3'd0},  // day 0
        '{14'd2024,  4'd4,  5'd31, 1'b1, 1'b0, 22'd0, 3'd0},  // past a 30-day month
        '{14'd2024,  4'd1,  5'd31, 1'b0, 1'b0, 22'd0, 3'd0},
        '{14'd2024,  4'd12, 5'd31, 1'b0, 1'b0, 22'd0, 3'd0},
        '{14'd1900,  4'd12, 5'd31, 1'b0, 1'b0, 22'd0, 3'd0},
        '{14'd9999,  4'd2,  5'd28, 1'b0, 1'b0, 22'd0, 3'd0},
        '{14'd8191,  4'd7,  5'd15, 1'b0, 1'b0, 22'd0, 3'd0}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // [13:0] year, [17:14] month, [22:18] day
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [21:0] day count, [24:22] weekday
    logic        m_axis_tuser;          // [0] date valid

    day_result_t pending_days [$];      // results still owed by the block
    int          mismatches = 0;
    int          cycles     = 0;
    bit          steady     = 1'b0;     // no gaps on either side while set
    bit          hold_req   = 1'b0;
    bit          hold_done  = 1'b0;

    date_to_day_number_weekday #(
        .MAX_YEAR (MAX_YEAR)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Length of a month in the Gregorian calendar, 0 for a bad month number.
    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            2:                       return leap ? 29 : 28;
            4, 6, 9, 11:             return 30;
            1, 3, 5, 7, 8, 10, 12:   return 31;
            default:                 return 0;
        endcase
    endfunction

    // Day number since 1899-12-31 and weekday, zeros for an invalid date.
    function automatic day_result_t date_to_daynum(input int unsigned y,
                                                   input int unsigned m,
                                                   input int unsigned d);
        day_result_t res;
        int unsigned total;
        int unsigned mo;
        res = '0;
        if (y < 1900 || y > MAX_YEAR) return res;
        if (m < 1 || m > 12) return res;
        if (d < 1 || d > days_in_month(y, m)) return res;
        total = d;
        for (mo = 1; mo < m; mo++) total += days_in_month(y, mo);
        // whole years since 1900 plus the leap days they hold
        total += (y - 1900) * 365;
        total += ((y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400)
               - (1899 / 4 - 1899 / 100 + 1899 / 400);
        res.ok    = 1'b1;
        res.count = total[21:0];
        res.wday  = 3'(total % 7);
        return res;
    endfunction

    // Idle length: mostly none, often short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one date; entered and left at a falling edge. The result is
    // queued at the edge where the transfer happens.
    task automatic send_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d,
                             input day_result_t result);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, d, m, y};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_days.push_back(result);
        @(negedge i_clk);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        day_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_days.size() == 0) begin
                report_mismatch("unexpected result, count", m_axis_tdata[21:0], 0);
            end else begin
                want = pending_days.pop_front();
                if (m_axis_tuser !== want.ok)
                    report_mismatch("date valid", m_axis_tuser, want.ok);
                if (m_axis_tdata[21:0] !== want.count)
                    report_mismatch("day count", m_axis_tdata[21:0], want.count);
                if (m_axis_tdata[24:22] !== want.wday)
                    report_mismatch("weekday", m_axis_tdata[24:22], want.wday);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here so the
    // four stages fill up and s_axis_tready has to drop.
    initial begin : receiver
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                stall = idle_len();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall - 1) @(negedge i_clk);
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    initial begin : sender
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int          pick;
        day_result_t res;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (DATE_ROWS[i].known)
                res = '{DATE_ROWS[i].ok, DATE_ROWS[i].count, DATE_ROWS[i].wday};
            else
                res = date_to_daynum(DATE_ROWS[i].year, DATE_ROWS[i].month, DATE_ROWS[i].day);
            send_date(DATE_ROWS[i].year, DATE_ROWS[i].month, DATE_ROWS[i].day, res);
        end

        // random dates
        for (int i = 0; i < RANDOM_DATES; i++) begin
            if (i == HOLD_AT) begin
                steady   = 1'b0;
                hold_req = 1'b1;
            end else if (i % 50 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            if (i == DRAIN_AT) begin
                // pause until the block has handed back everything
                s_axis_tvalid <= 1'b0;
                wait (pending_days.size() == 0);
                @(negedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                y = $urandom_range(1900, MAX_YEAR);
                m = $urandom_range(1, 12);
                d = $urandom_range(1, days_in_month(y, m));
            end else if (pick < 85) begin
                // near year bounds, centuries, years 1900+4k, last day or one past
                case ($urandom_range(0, 4))
                    0:       y = 1899 + $urandom_range(0, 1);
                    1:       y = MAX_YEAR + $urandom_range(0, 1);
                    2:       y = 1900 + 100 * $urandom_range(0, 80);
                    3:       y = 1900 + 4 * $urandom_range(0, 2024);
                    default: y = $urandom_range(1900, MAX_YEAR);
                endcase
                m = $urandom_range(1, 12);
                d = days_in_month(y, m) + $urandom_range(0, 1);
            end else begin
                y = $urandom_range(0, 16383);
                m = $urandom_range(0, 15);
                d = $urandom_range(0, 31);
            end
            send_date(14'(y), 4'(m), 5'(d), date_to_daynum(y, m, d));
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;

        wait (pending_days.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
